[rtl/core/ipv4_header_receive_check_assert.svh]
// ----------------------------------------------------------------------------
// IPv4 header receive check assertion macros
// Shorthand for clocked concurrent assertions used in the RTL.
// ----------------------------------------------------------------------------
`ifndef IPV4_HEADER_RECEIVE_CHECK_ASSERT_SVH
`define IPV4_HEADER_RECEIVE_CHECK_ASSERT_SVH

// Assertion checked only while reset is released.
`define IHRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assertion checked at every clock edge, reset included.
`define IHRC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/core/ihrc_pkg.sv]
// ----------------------------------------------------------------------------
// IPv4 header receive check package
// Field widths, header byte offsets and verdict codes.
// ----------------------------------------------------------------------------
package ihrc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 16;
  localparam int unsigned SumW    = 20;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned CsumW   = 16;
  localparam int unsigned InDataW = 8;
  localparam int unsigned OutDataW = 24;

  localparam logic [CountW-1:0] CountMax    = 16'hffff;
  localparam logic [CountW-1:0] HdrMinBytes = 16'd20;
  localparam logic [3:0]        IpVersion4  = 4'd4;
  localparam logic [3:0]        CsumWordIdx = 4'd5;

  // Header byte offsets.
  localparam logic [4:0] OffVerIhl    = 5'd0;
  localparam logic [4:0] OffTtl       = 5'd8;
  localparam logic [4:0] OffCsumHi    = 5'd10;
  localparam logic [4:0] OffCsumLo    = 5'd11;
  localparam logic [4:0] OffDestFirst = 5'd16;

  localparam logic [AddrW-1:0] LocalAddrReset = '0;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT   = 3'd0,
    VERDICT_VERSION  = 3'd1,
    VERDICT_HDR_LEN  = 3'd2,
    VERDICT_TTL      = 3'd3,
    VERDICT_DEST     = 3'd4,
    VERDICT_CHECKSUM = 3'd5
  } verdict_e;

endpackage

[rtl/core/ipv4_header_receive_check.sv]
// ----------------------------------------------------------------------------
// IPv4 header receive check
// Byte-stream IPv4 header parser giving one accept/reject verdict per packet.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis_*  : one packet byte per transaction, tlast on the final byte.
//   m_axis_*  : one verdict transaction per packet, issued for the tlast byte.
//   cfg_wr_*  : local address register, write while the block is idle.
// Every accepted byte updates the running header state in the same cycle
// (capture, 16-bit word sum, saturating byte count). The tlast byte copies the
// final state into a snapshot register and clears the running state, so the
// next packet may start in the following cycle.
// Path: accepting the tlast byte loads the snapshot register; the check result
// on the snapshot then loads the output register once it is free, which
// raises m_axis_tvalid.
// Throughput: one byte per cycle while s_axis_tready is high; back-to-back
// packets of any length, one byte each included.
// Stall: the output register and the snapshot each hold one verdict; when
// both are full and m_axis_tready is low, s_axis_tready drops.
// Reset: all packet state and the snapshot and output valid flags are
// cleared, and the local address returns to zero.
// ----------------------------------------------------------------------------
`include "ipv4_header_receive_check_assert.svh"

module ipv4_header_receive_check (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Local address register
  input  logic                             cfg_wr_en_i,
  input  logic [ihrc_pkg::AddrW-1:0]       cfg_wr_data_i,
  // Byte stream in
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ihrc_pkg::InDataW-1:0]     s_axis_tdata,   // [7:0] data_byte
  input  logic                             s_axis_tlast,   // last_byte
  // Verdict out
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [ihrc_pkg::OutDataW-1:0]    m_axis_tdata    // [2:0] verdict,
                                                           // [18:3] packet_length,
                                                           // [23:19] zero
);

  // Configuration
  logic [ihrc_pkg::AddrW-1:0]  local_addr_q;

  // Running packet state
  logic [ihrc_pkg::CountW-1:0] byte_count_q, byte_count_d;
  logic [ihrc_pkg::SumW-1:0]   word_sum_q, word_sum_d;
  logic [ihrc_pkg::ByteW-1:0]  held_byte_q, held_byte_d;
  logic [ihrc_pkg::ByteW-1:0]  ver_ihl_q, ver_ihl_d;
  logic [ihrc_pkg::ByteW-1:0]  ttl_q, ttl_d;
  logic [ihrc_pkg::AddrW-1:0]  dest_q, dest_d;
  logic [ihrc_pkg::CsumW-1:0]  csum_q, csum_d;

  // Snapshot of a finished packet
  logic                        snap_valid_q;
  logic [ihrc_pkg::CountW-1:0] snap_len_q;
  logic [ihrc_pkg::SumW-1:0]   snap_sum_q;
  logic [ihrc_pkg::ByteW-1:0]  snap_ver_ihl_q;
  logic [ihrc_pkg::ByteW-1:0]  snap_ttl_q;
  logic [ihrc_pkg::AddrW-1:0]  snap_dest_q;
  logic [ihrc_pkg::CsumW-1:0]  snap_csum_q;

  // Output register
  logic                        out_valid_q;
  ihrc_pkg::verdict_e          out_verdict_q, verdict_d;
  logic [ihrc_pkg::CountW-1:0] out_len_q;

  logic                        snap_adv;
  logic                        in_fire;
  logic [ihrc_pkg::ByteW-1:0]  in_byte;
  logic                        hdr_byte;
  logic [4:0]                  hdr_idx;

  assign in_byte  = s_axis_tdata;
  assign snap_adv = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !snap_valid_q || snap_adv;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign hdr_byte = byte_count_q < ihrc_pkg::HdrMinBytes;
  assign hdr_idx  = byte_count_q[4:0];

  // --------------------------------------------------------------------------
  // Per-byte state update
  // --------------------------------------------------------------------------
  always_comb begin
    word_sum_d  = word_sum_q;
    held_byte_d = held_byte_q;
    ver_ihl_d   = ver_ihl_q;
    ttl_d       = ttl_q;
    dest_d      = dest_q;
    csum_d      = csum_q;
    if (hdr_byte) begin
      if (hdr_idx[0]) begin
        // Low byte completes a word; skip the checksum word itself.
        if (hdr_idx[4:1] != ihrc_pkg::CsumWordIdx) begin
          word_sum_d = word_sum_q + {4'b0, held_byte_q, in_byte};
        end
      end else begin
        held_byte_d = in_byte;
      end
      case (hdr_idx)
        ihrc_pkg::OffVerIhl: ver_ihl_d = in_byte;
        ihrc_pkg::OffTtl:    ttl_d     = in_byte;
        ihrc_pkg::OffCsumHi: csum_d    = {in_byte, csum_q[7:0]};
        ihrc_pkg::OffCsumLo: csum_d    = {csum_q[15:8], in_byte};
        default: begin
          // Destination arrives big-endian: shift it in.
          if (hdr_idx >= ihrc_pkg::OffDestFirst) begin
            dest_d = {dest_q[23:0], in_byte};
          end
        end
      endcase
    end
    byte_count_d = (byte_count_q == ihrc_pkg::CountMax) ? byte_count_q
                                                        : byte_count_q + 16'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= ihrc_pkg::LocalAddrReset;
      byte_count_q <= '0;
      word_sum_q   <= '0;
      held_byte_q  <= '0;
      ver_ihl_q    <= '0;
      ttl_q        <= '0;
      dest_q       <= '0;
      csum_q       <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        local_addr_q <= cfg_wr_data_i;
      end
      if (in_fire && s_axis_tlast) begin
        snap_valid_q <= 1'b1;
      end else if (snap_adv) begin
        snap_valid_q <= 1'b0;
      end
      if (in_fire) begin
        if (s_axis_tlast) begin
          // Clear for the next packet; the snapshot carries this one.
          byte_count_q <= '0;
          word_sum_q   <= '0;
          held_byte_q  <= '0;
          ver_ihl_q    <= '0;
          ttl_q        <= '0;
          dest_q       <= '0;
          csum_q       <= '0;
        end else begin
          byte_count_q <= byte_count_d;
          word_sum_q   <= word_sum_d;
          held_byte_q  <= held_byte_d;
          ver_ihl_q    <= ver_ihl_d;
          ttl_q        <= ttl_d;
          dest_q       <= dest_d;
          csum_q       <= csum_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && s_axis_tlast) begin
      snap_len_q     <= byte_count_d;
      snap_sum_q     <= word_sum_d;
      snap_ver_ihl_q <= ver_ihl_d;
      snap_ttl_q     <= ttl_d;
      snap_dest_q    <= dest_d;
      snap_csum_q    <= csum_d;
    end
  end

  // --------------------------------------------------------------------------
  // Verdict logic on the snapshot
  // --------------------------------------------------------------------------
  logic [16:0]                 fold1;
  logic [15:0]                 fold2;
  logic [ihrc_pkg::CsumW-1:0]  calc_csum;
  logic [ihrc_pkg::CountW-1:0] hdr_len;
  logic                        dest_local;
  logic [ihrc_pkg::AddrW-1:0]  low_mask;

  always_comb begin
    // Two end-around folds bring a 20-bit sum into 16 bits.
    fold1     = {1'b0, snap_sum_q[15:0]} + {13'b0, snap_sum_q[19:16]};
    fold2     = fold1[15:0] + {15'b0, fold1[16]};
    calc_csum = ~fold2;
    hdr_len   = {10'b0, snap_ver_ihl_q[3:0], 2'b00};

    dest_local = (snap_dest_q == local_addr_q) || (snap_dest_q == '1);
    low_mask   = '0;
    for (int k = 1; k < 32; k++) begin
      low_mask = ~({ihrc_pkg::AddrW{1'b1}} << k);
      if ((local_addr_q & low_mask) == snap_dest_q) begin
        dest_local = 1'b1;
      end
    end

    if (snap_ver_ihl_q[7:4] != ihrc_pkg::IpVersion4) begin
      verdict_d = ihrc_pkg::VERDICT_VERSION;
    end else if (hdr_len < ihrc_pkg::HdrMinBytes || hdr_len > snap_len_q) begin
      verdict_d = ihrc_pkg::VERDICT_HDR_LEN;
    end else if (snap_ttl_q == '0) begin
      verdict_d = ihrc_pkg::VERDICT_TTL;
    end else if (!dest_local) begin
      verdict_d = ihrc_pkg::VERDICT_DEST;
    end else if (snap_csum_q != calc_csum) begin
      verdict_d = ihrc_pkg::VERDICT_CHECKSUM;
    end else begin
      verdict_d = ihrc_pkg::VERDICT_ACCEPT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (snap_adv) begin
      out_valid_q <= snap_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_adv && snap_valid_q) begin
      out_verdict_q <= verdict_d;
      out_len_q     <= snap_len_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_len_q, out_verdict_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `IHRC_ASSERT(a_last_clears_count, in_fire && s_axis_tlast |=> byte_count_q == '0, "byte count not cleared after last byte")
  `IHRC_ASSERT(a_count_advances, in_fire && !s_axis_tlast && byte_count_q != ihrc_pkg::CountMax |=> byte_count_q == $past(byte_count_q) + 16'd1, "byte count did not advance")
  `IHRC_ASSERT(a_snap_moves_out, snap_valid_q && snap_adv |=> out_valid_q, "snapshot lost on the way to the output")
  `IHRC_ASSERT(a_accept_min_len, out_valid_q && out_verdict_q == ihrc_pkg::VERDICT_ACCEPT |-> out_len_q >= ihrc_pkg::HdrMinBytes, "accepted packet shorter than a header")
  `IHRC_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !m_axis_tvalid, "output valid during reset")

endmodule
